@@ rtl/ps2mt_pkg.sv @@
`default_nettype none

package ps2mt_pkg;

    // field widths
    localparam int BYTE_W = 8;
    localparam int POS_W  = 12;
    localparam int OUT_W  = 10;
    localparam int BTN_W  = 3;

    // packet format
    localparam int SYNC_BIT   = 3;
    localparam int PACKET_LEN = 3;

    // position of the next byte within a packet
    localparam logic [1:0] IDX_FLAG = 2'd0;
    localparam logic [1:0] IDX_DX   = 2'd1;
    localparam logic [1:0] IDX_DY   = 2'd2;

    typedef logic [POS_W-1:0] pos_t;

    // one received byte waiting in the input register
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } beat_t;

    // result beat, pos_x in the lowest bits
    typedef struct packed {
        logic [BTN_W-1:0] buttons;
        logic [OUT_W-1:0] pos_y;
        logic [OUT_W-1:0] pos_x;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

@@ rtl/ps2mt_in_stage.sv @@
`default_nettype none

module ps2mt_in_stage
    import ps2mt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [BYTE_W-1:0] s_axis_tdata,   // rx_byte[7:0]
    output beat_t                  beat,
    input  wire logic              take
);

    logic              valid_reg;
    logic [BYTE_W-1:0] data_reg;

    // room when empty or when the held beat leaves this cycle
    assign s_axis_tready = !valid_reg || take;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    // byte capture
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            data_reg <= s_axis_tdata;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;

endmodule

`default_nettype wire

@@ rtl/ps2mt_core.sv @@
`default_nettype none

module ps2mt_core
    import ps2mt_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire beat_t   beat,
    output logic         take,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    localparam logic [POS_W:0]   SIZE_X  = (POS_W+1)'(SCREEN_WIDTH);
    localparam logic [POS_W:0]   SIZE_Y  = (POS_W+1)'(SCREEN_HEIGHT);
    localparam logic [POS_W-1:0] RESET_X = POS_W'(SCREEN_WIDTH / 2);
    localparam logic [POS_W-1:0] RESET_Y = POS_W'(SCREEN_HEIGHT / 2);

    // clamp a signed position to 0..size-1
    function automatic pos_t clamp_pos(input logic [POS_W+1:0] v, input logic [POS_W:0] size);
        pos_t r;
        if (v[POS_W+1])
        begin
            r = '0;
        end
        else if (v[POS_W:0] >= size)
        begin
            r = POS_W'(size - 1'b1);
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    logic [1:0]        idx_reg,  idx_next;
    logic [BTN_W-1:0]  btn_reg,  btn_next;
    logic [BYTE_W-1:0] dx_reg,   dx_next;
    pos_t              cur_x_reg, cur_x_next;
    pos_t              cur_y_reg, cur_y_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg,  out_data_next;

    logic [POS_W+1:0]  nx;
    logic [POS_W+1:0]  ny;
    logic              emit;

    // take the held byte when the result register can hold a new beat
    assign take = beat.valid && (!out_valid_reg || out_ready);

    // new positions from the kept x delta and the y delta byte now held
    assign nx = {2'b00, cur_x_reg} + {{(POS_W+2-BYTE_W){dx_reg[BYTE_W-1]}}, dx_reg};
    assign ny = {2'b00, cur_y_reg} - {{(POS_W+2-BYTE_W){beat.data[BYTE_W-1]}}, beat.data};

    // packet assembly
    always_comb
    begin
        idx_next   = idx_reg;
        btn_next   = btn_reg;
        dx_next    = dx_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        emit       = 1'b0;
        if (take)
        begin
            unique case (idx_reg)
                IDX_FLAG:
                begin
                    // drop bytes until the sync bit shows a packet start
                    if (beat.data[SYNC_BIT])
                    begin
                        btn_next = beat.data[BTN_W-1:0];
                        idx_next = IDX_DX;
                    end
                end
                IDX_DX:
                begin
                    dx_next  = beat.data;
                    idx_next = IDX_DY;
                end
                default:
                begin
                    cur_x_next = clamp_pos(nx, SIZE_X);
                    cur_y_next = clamp_pos(ny, SIZE_Y);
                    idx_next   = IDX_FLAG;
                    emit       = 1'b1;
                end
            endcase
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next        = 1'b1;
            out_data_next.pos_x   = cur_x_next[OUT_W-1:0];
            out_data_next.pos_y   = cur_y_next[OUT_W-1:0];
            out_data_next.buttons = btn_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= IDX_FLAG;
            btn_reg       <= '0;
            dx_reg        <= '0;
            cur_x_reg     <= RESET_X;
            cur_y_reg     <= RESET_Y;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            btn_reg       <= btn_next;
            dx_reg        <= dx_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    a_x_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cur_x_reg} < SIZE_X)
        else $error("cursor column outside the screen");

    a_y_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cur_y_reg} < SIZE_Y)
        else $error("cursor row outside the screen");

    a_dx_then_dy: assert property (@(posedge clk) disable iff (!rst_n)
        (take && idx_reg == IDX_DX) |=> (idx_reg == IDX_DY))
        else $error("delta x byte not followed by delta y slot");

    a_no_result_mid_packet: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (idx_reg == IDX_FLAG || idx_reg == IDX_DX))
        |=> (out_valid_reg == ($past(out_valid_reg) && !$past(out_ready))))
        else $error("result produced before the third byte");

    a_third_byte_result: assert property (@(posedge clk) disable iff (!rst_n)
        (take && idx_reg == IDX_DY) |=> (out_valid_reg && idx_reg == IDX_FLAG))
        else $error("third byte gave no result");

endmodule

`default_nettype wire

@@ rtl/ps2_mouse_packet_tracker.sv @@
// the third packet byte passes the input register and then the result register to its result beat
// throughput: one byte per cycle while the result side keeps tready high
// rate is set by the single input register and the single result register
// reset: asynchronous, active low; cursor returns to the screen center,
// packet assembly restarts at the flag byte and both stages empty
`default_nettype none

module ps2_mouse_packet_tracker
    import ps2mt_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [BYTE_W-1:0]  s_axis_tdata,   // rx_byte[7:0]
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata    // pos_x[9:0], pos_y[19:10], buttons[22:20]
);

    beat_t   beat;
    logic    take;
    result_t result;

    // input register
    ps2mt_in_stage u_in_stage
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .beat          (beat),
        .take          (take)
    );

    // packet assembly, position update and result register
    ps2mt_core #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .take      (take),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (result)
    );

    // pad the result beat to whole bytes
    assign m_axis_tdata = TDATA_W'(result);

endmodule

`default_nettype wire
